// File: src/four_dim_box_bin_classifier_top_macros.svh
// ----------------------------------------------------------------------------
// four_dim_box_bin_classifier_top_macros
// assertion helpers used by the checker of the box classifier
// ----------------------------------------------------------------------------
`ifndef FOUR_DIM_BOX_BIN_CLASSIFIER_TOP_MACROS_SVH
`define FOUR_DIM_BOX_BIN_CLASSIFIER_TOP_MACROS_SVH

// clocked assertion, quiet while reset is held
`define FDBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication
`define FDBC_ASSERT_IMP(lbl, ante, cons, msg) \
    `FDBC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: src/fdbc_pkg.sv
// ----------------------------------------------------------------------------
// fdbc_pkg
// constants, codes and types of the four-dimensional box classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdbc_pkg;

    // sizing
    localparam int BOXES_PER_SIGNAL = 64;
    localparam int SIGNAL_TYPES     = 4;
    localparam int COORD_WIDTH      = 32;
    localparam int NUM_COUNT_REGS   = 4;
    localparam int NUM_COORDS       = 4;
    localparam int TABLE_DEPTH      = SIGNAL_TYPES * BOXES_PER_SIGNAL;
    localparam int ROW_W            = NUM_COORDS * COORD_WIDTH;

    // field widths of the channels
    localparam int ACTION_W = 2;
    localparam int SIGIN_W  = 3;
    localparam int BOXIN_W  = 6;
    localparam int MATCH_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SIG_W  = (SIGNAL_TYPES > 1) ? $clog2(SIGNAL_TYPES) : 1;
    localparam int BOX_W  = (BOXES_PER_SIGNAL > 1) ? $clog2(BOXES_PER_SIGNAL) : 1;
    localparam int CNT_W  = $clog2(BOXES_PER_SIGNAL + 1);

    // item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLASSIFY    = 2'd0,
        ACT_WRITE_LOWER = 2'd1,
        ACT_WRITE_UPPER = 2'd2,
        ACT_NONE        = 2'd3
    } t_action;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: src/fdbc_if.sv
// ----------------------------------------------------------------------------
// fdbc_if
// valid/ready channels of the box classifier: items, results, register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fdbc_item_if import fdbc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [SIGIN_W-1:0]       signal_type;
    logic [BOXIN_W-1:0]       box_number;
    logic signed [COORD_WIDTH-1:0] coord_one;
    logic signed [COORD_WIDTH-1:0] coord_two;
    logic signed [COORD_WIDTH-1:0] coord_three;
    logic signed [COORD_WIDTH-1:0] coord_four;

    modport source (output valid, action, signal_type, box_number,
                    coord_one, coord_two, coord_three, coord_four, input ready);
    modport sink   (input valid, action, signal_type, box_number,
                    coord_one, coord_two, coord_three, coord_four, output ready);
endinterface

interface fdbc_result_if import fdbc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MATCH_W-1:0] matched_box;
    logic               found;
    logic               bad_signal;

    modport source (output valid, matched_box, found, bad_signal, input ready);
    modport sink   (input valid, matched_box, found, bad_signal, output ready);
endinterface

interface fdbc_cfg_if import fdbc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COUNT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/fdbc_ram.sv
// ----------------------------------------------------------------------------
// fdbc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                   i_wdata,
    input  wire logic                               i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                   o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/four_dim_box_bin_classifier_top.sv
// Load items write the bounds at the accepting edge.
// A classify item reads one stored box per cycle from the bound rams, so the
// result follows a scan of at most count boxes (count saturates at 64).
// The next item is accepted once the scan has handed its result on; an unknown
// signal answers without a scan. Synchronous active-low reset clears the counts and
// control state; box bounds are not cleared and must be written before use.
// ----------------------------------------------------------------------------
// four_dim_box_bin_classifier_top
// per-signal four-dimensional box tables with first-match classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_dim_box_bin_classifier_top
    import fdbc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fdbc_item_if.sink   i_item,
    fdbc_result_if.source o_result,
    fdbc_cfg_if.sink    i_cfg
);

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_count [NUM_COUNT_REGS];

    logic signed [COORD_WIDTH-1:0] r_coord [NUM_COORDS];
    logic [SIG_W-1:0]   r_sig;
    logic [CNT_W-1:0]   r_lim;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_cmp_valid, n_cmp_valid;
    logic [BOX_W-1:0]   r_cmp_idx, n_cmp_idx;

    logic [MATCH_W-1:0] r_res_box, n_res_box;
    logic               r_res_found, n_res_found;
    logic               r_res_bad, n_res_bad;
    logic               res_load;

    logic               r_out_valid;
    logic [MATCH_W-1:0] r_out_box;
    logic               r_out_found;
    logic               r_out_bad;
    logic               out_load;

    logic               item_accept;
    logic               sig_ok;
    logic               box_ok;
    logic [COUNT_W-1:0] sel_count;
    logic [CNT_W-1:0]   sat_count;
    logic [SIG_W-1:0]   in_sig;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [ROW_W-1:0]   wdata;
    logic               we_lower;
    logic               we_upper;
    logic               ram_re;
    logic [ROW_W-1:0]   lower_row;
    logic [ROW_W-1:0]   upper_row;
    logic               hit;

    // configuration writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COUNT_REGS; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_cfg.valid && (32'(i_cfg.index) < NUM_COUNT_REGS)) begin
            r_count[i_cfg.index] <= i_cfg.data;
        end
    end

    // item decode
    assign i_item.ready = (r_state == ST_IDLE);
    assign item_accept  = i_item.valid && i_item.ready;
    assign sig_ok       = (32'(i_item.signal_type) < SIGNAL_TYPES) &&
                          (32'(i_item.signal_type) < NUM_COUNT_REGS);
    assign box_ok       = 32'(i_item.box_number) < BOXES_PER_SIGNAL;
    assign in_sig       = SIG_W'(i_item.signal_type);
    assign sel_count    = r_count[i_item.signal_type[CFG_IDX_W-1:0]];
    assign sat_count    = (32'(sel_count) > BOXES_PER_SIGNAL) ?
                          CNT_W'(BOXES_PER_SIGNAL) : CNT_W'(sel_count);

    // bound table writes
    assign waddr    = ADDR_W'(ADDR_W'(in_sig) * ADDR_W'(BOXES_PER_SIGNAL)) +
                      ADDR_W'(BOX_W'(i_item.box_number));
    assign wdata    = {i_item.coord_four, i_item.coord_three,
                       i_item.coord_two, i_item.coord_one};
    assign we_lower = item_accept && sig_ok && box_ok &&
                      (i_item.action == ACT_WRITE_LOWER);
    assign we_upper = item_accept && sig_ok && box_ok &&
                      (i_item.action == ACT_WRITE_UPPER);

    // scan read address
    assign raddr = ADDR_W'(ADDR_W'(r_sig) * ADDR_W'(BOXES_PER_SIGNAL)) +
                   ADDR_W'(r_idx[BOX_W-1:0]);

    fdbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (we_lower),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (lower_row)
    );

    fdbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (we_upper),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (upper_row)
    );

    // half-open containment test on all coordinates
    always_comb begin
        hit = 1'b1;
        for (int k = 0; k < NUM_COORDS; k++) begin
            if (!((r_coord[k] >= $signed(lower_row[k*COORD_WIDTH +: COORD_WIDTH])) &&
                  (r_coord[k] <  $signed(upper_row[k*COORD_WIDTH +: COORD_WIDTH])))) begin
                hit = 1'b0;
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and scan control
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmp_valid = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        ram_re      = 1'b0;
        res_load    = 1'b0;
        n_res_box   = '0;
        n_res_found = 1'b0;
        n_res_bad   = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (item_accept && (i_item.action == ACT_CLASSIFY)) begin
                    n_idx = '0;
                    if (!sig_ok) begin
                        res_load  = 1'b1;
                        n_res_bad = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cmp_valid && hit) begin
                    res_load    = 1'b1;
                    n_res_found = 1'b1;
                    n_res_box   = MATCH_W'(r_cmp_idx);
                    n_state     = ST_DONE;
                end else if (r_idx >= r_lim) begin
                    res_load = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    ram_re      = 1'b1;
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[BOX_W-1:0];
                    n_idx       = r_idx + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // scan control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_cmp_valid <= n_cmp_valid;
            r_idx       <= n_idx;
        end
    end

    // classify payload and scan tags
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        if (item_accept && (i_item.action == ACT_CLASSIFY)) begin
            r_sig      <= in_sig;
            r_lim      <= sat_count;
            r_coord[0] <= i_item.coord_one;
            r_coord[1] <= i_item.coord_two;
            r_coord[2] <= i_item.coord_three;
            r_coord[3] <= i_item.coord_four;
        end
        if (res_load) begin
            r_res_box   <= n_res_box;
            r_res_found <= n_res_found;
            r_res_bad   <= n_res_bad;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_box   <= r_res_box;
            r_out_found <= r_res_found;
            r_out_bad   <= r_res_bad;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.matched_box = r_out_box;
    assign o_result.found       = r_out_found;
    assign o_result.bad_signal  = r_out_bad;

endmodule

`default_nettype wire

// File: src/fdbc_checker.sv
// ----------------------------------------------------------------------------
// fdbc_checker
// port-level checks of the box classifier, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "four_dim_box_bin_classifier_top_macros.svh"

module fdbc_checker
    import fdbc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_item_valid,
    input wire logic               i_item_ready,
    input wire logic [ACTION_W-1:0] i_item_action,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire logic [MATCH_W-1:0] i_res_box,
    input wire logic               i_res_found,
    input wire logic               i_res_bad
);

    logic       classify_acc;
    logic       result_acc;
    logic [1:0] r_pend;

    assign classify_acc = i_item_valid && i_item_ready && (i_item_action == ACT_CLASSIFY);
    assign result_acc   = i_res_valid && i_res_ready;

    // classify transactions whose result has not been taken yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (classify_acc && !result_acc) begin
            r_pend <= r_pend + 2'd1;
        end else if (result_acc && !classify_acc) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // a stalled result holds
    `FDBC_ASSERT(a_res_hold, (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_box) && $stable(i_res_found) && $stable(i_res_bad)), "stalled result changed")

    // every result belongs to an earlier classify
    `FDBC_ASSERT_IMP(a_res_owned, i_res_valid, r_pend != 2'd0, "result without classify")

    // at most one scan plus one waiting result
    `FDBC_ASSERT_IMP(a_pend_bound, 1'b1, r_pend != 2'd3, "too many classify transactions in flight")

    // failed lookups report box zero, bad signal never finds
    `FDBC_ASSERT_IMP(a_res_codes, i_res_valid && !i_res_found, (i_res_box == '0), "miss with nonzero box")
    `FDBC_ASSERT_IMP(a_bad_nofind, i_res_valid && i_res_bad, !i_res_found, "bad signal reported a match")

endmodule

bind four_dim_box_bin_classifier_top fdbc_checker u_fdbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_item_valid  (i_item.valid),
    .i_item_ready  (i_item.ready),
    .i_item_action (i_item.action),
    .i_res_valid   (o_result.valid),
    .i_res_ready   (o_result.ready),
    .i_res_box     (o_result.matched_box),
    .i_res_found   (o_result.found),
    .i_res_bad     (o_result.bad_signal)
);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-dimensional box classifier. Loads every
// box table, then runs a directed table and random traffic under several box
// counts. Each classify answer is checked against a bench-side copy of the
// tables, while the source sends in bursts and the result sink stalls.
// ----------------------------------------------------------------------------

module tb_top;
    import fdbc_pkg::*;

    localparam int     CLK_HIGH_NS = 6;
    localparam int     CLK_LOW_NS  = 6;
    localparam int     DRAIN_PAD   = 80;          // longer than a full 64-box scan
    localparam longint LIMIT_NS    = 40_000_000;
    localparam int     PHASE_ITEMS = 180;
    localparam int     NUM_PHASES  = 5;
    localparam int     ONE_Q       = 1 << 16;     // 1.0 in Q16.16

    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [COORD_WIDTH-1:0] C_MAX = ~C_MIN;
    localparam logic [COORD_WIDTH-1:0] C_ONE = COORD_WIDTH'(ONE_Q);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BINS_SIG0,
        REG_BINS_SIG1,
        REG_BINS_SIG2,
        REG_BINS_SIG3
    } t_count_reg;

    typedef logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] t_point;

    typedef struct packed {
        t_action              act;
        logic [SIGIN_W-1:0]   sig;
        logic [BOXIN_W-1:0]   box;
        t_point               coord;
    } t_item;

    typedef struct packed {
        logic [MATCH_W-1:0] matched_box;
        logic               found;
        logic               bad_signal;
    } t_verdict;

    typedef struct packed {
        logic               is_cfg;
        logic               is_typed;
        t_item              item;
        t_verdict           typed;
        t_count_reg         reg_idx;
        logic [COUNT_W-1:0] reg_val;
    } t_row;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic sink_ready = 1'b0;

    fdbc_item_if   item_if ();
    fdbc_result_if res_if ();
    fdbc_cfg_if    cfg_if ();

    assign res_if.ready = sink_ready;

    four_dim_box_bin_classifier_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (res_if.source),
        .i_cfg    (cfg_if.sink)
    );

    // bench copy of the box tables and the box counts
    logic signed [COORD_WIDTH-1:0] lower_tab [TABLE_DEPTH][NUM_COORDS];
    logic signed [COORD_WIDTH-1:0] upper_tab [TABLE_DEPTH][NUM_COORDS];
    logic [COUNT_W-1:0]            bin_count [NUM_COUNT_REGS];

    t_verdict pending_verdicts [$];
    t_row     directed_rows [$];
    int       mismatches = 0;
    int       burst_left = 0;
    int       gap_next   = 0;

    // sink stall pattern state
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_run       = 0;

    // clock
    always begin
        #CLK_HIGH_NS i_clk = 1'b1;
        #CLK_LOW_NS  i_clk = 1'b0;
    end

    // run limit
    initial begin
        #LIMIT_NS;
        $display("four_dim_box_bin_classifier_top regression: fail");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // boxes scanned for a signal, count saturates at the table size
    function automatic int boxes_in_use(input int sig);
        int n;
        n = int'(bin_count[sig]);
        return (n > BOXES_PER_SIGNAL) ? BOXES_PER_SIGNAL : n;
    endfunction

    // apply one transaction to the bench tables; classify gives a verdict
    function automatic void lookup_item(input t_item it, output bit answers,
                                        output t_verdict v);
        int row;
        int n;
        int i;
        int k;
        bit hit;
        bit sig_ok;
        v       = '0;
        answers = 1'b0;
        sig_ok  = (it.sig < SIGNAL_TYPES) && (it.sig < NUM_COUNT_REGS);
        case (it.act)
            ACT_WRITE_LOWER, ACT_WRITE_UPPER: begin
                if (sig_ok && it.box < BOXES_PER_SIGNAL) begin
                    row = int'(it.sig) * BOXES_PER_SIGNAL + int'(it.box);
                    for (k = 0; k < NUM_COORDS; k++) begin
                        if (it.act == ACT_WRITE_LOWER) lower_tab[row][k] = it.coord[k];
                        else upper_tab[row][k] = it.coord[k];
                    end
                end
            end
            ACT_CLASSIFY: begin
                answers = 1'b1;
                if (!sig_ok) begin
                    v.bad_signal = 1'b1;
                end else begin
                    n = boxes_in_use(int'(it.sig));
                    for (i = 0; i < n && !v.found; i++) begin
                        row = int'(it.sig) * BOXES_PER_SIGNAL + i;
                        hit = 1'b1;
                        for (k = 0; k < NUM_COORDS; k++) begin
                            if (!($signed(it.coord[k]) >= lower_tab[row][k] &&
                                  $signed(it.coord[k]) < upper_tab[row][k]))
                                hit = 1'b0;
                        end
                        if (hit) begin
                            v.found       = 1'b1;
                            v.matched_box = i[MATCH_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // choose the source's next gap and burst length
    function automatic void plan_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)      gap_next = $urandom_range(1, 4);
        else if (r < 93) gap_next = $urandom_range(5, 15);
        else             gap_next = $urandom_range(20, 90);
        r = $urandom_range(0, 99);
        burst_left = (r < 85) ? $urandom_range(1, 10) : $urandom_range(25, 70);
    endfunction

    // offer one transaction, wait for acceptance, record its verdict
    task automatic send_item(input t_item it, input bit use_typed, input t_verdict typed);
        bit       answers;
        t_verdict v;
        if (gap_next > 0) begin
            repeat (gap_next) @(posedge i_clk);
            gap_next = 0;
        end
        item_if.valid       <= 1'b1;
        item_if.action      <= it.act;
        item_if.signal_type <= it.sig;
        item_if.box_number  <= it.box;
        item_if.coord_one   <= it.coord[0];
        item_if.coord_two   <= it.coord[1];
        item_if.coord_three <= it.coord[2];
        item_if.coord_four  <= it.coord[3];
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        lookup_item(it, answers, v);
        if (answers) pending_verdicts = {pending_verdicts, (use_typed ? typed : v)};
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            item_if.valid <= 1'b0;
            plan_idle();
        end
    endtask

    // drop valid right after the last accepted transaction
    task automatic hold_items();
        if (burst_left > 0) begin
            item_if.valid <= 1'b0;
            plan_idle();
        end
    endtask

    task automatic wait_drained();
        hold_items();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_count(input t_count_reg idx, input logic [COUNT_W-1:0] val,
                               input bit last);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        bin_count[idx] = val;
        if (last) cfg_if.valid <= 1'b0;
    endtask

    task automatic load_counts(input int c0, input int c1, input int c2, input int c3);
        wait_drained();
        write_count(REG_BINS_SIG0, COUNT_W'(c0), 1'b0);
        write_count(REG_BINS_SIG1, COUNT_W'(c1), 1'b0);
        write_count(REG_BINS_SIG2, COUNT_W'(c2), 1'b0);
        write_count(REG_BINS_SIG3, COUNT_W'(c3), 1'b1);
    endtask

    // mostly small grid values, some extremes, some full-range noise
    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return COORD_WIDTH'((int'($urandom_range(0, 16)) - 8) * ONE_Q +
                   (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, ONE_Q - 1)) : 0));
        end else if (r < 65) begin
            case ($urandom_range(0, 5))
                0:       return C_MIN;
                1:       return C_MAX;
                2:       return '0;
                3:       return '1;
                4:       return C_MIN + 1;
                default: return C_MAX - 1;
            endcase
        end
        return $urandom;
    endfunction

    // bounds of one box: mostly proper, sometimes empty, inverted or unbounded
    function automatic void pick_box(output t_point lo, output t_point hi);
        int k;
        int r;
        int base;
        for (k = 0; k < NUM_COORDS; k++) begin
            r    = $urandom_range(0, 99);
            base = (int'($urandom_range(0, 12)) - 6) * ONE_Q +
                   (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, ONE_Q - 1)) : 0);
            lo[k] = COORD_WIDTH'(base);
            if (r < 88)      hi[k] = COORD_WIDTH'(base + int'($urandom_range(1, 6)) * ONE_Q);
            else if (r < 91) hi[k] = COORD_WIDTH'(base);
            else if (r < 93) hi[k] = COORD_WIDTH'(base - ONE_Q);
            else if (r < 96) begin
                lo[k] = C_MIN;
                hi[k] = COORD_WIDTH'(base + ONE_Q);
            end else hi[k] = C_MAX;
        end
    endfunction

    // coordinate near a box edge or inside it
    function automatic logic [COORD_WIDTH-1:0] pick_near(input logic signed [COORD_WIDTH-1:0] lo,
                                                        input logic signed [COORD_WIDTH-1:0] hi);
        longint span;
        int     r;
        if (lo >= hi) return pick_coord();
        span = longint'(hi) - longint'(lo);
        r    = $urandom_range(0, 99);
        if (r < 60) return COORD_WIDTH'(longint'(lo) + (longint'($urandom) % span));
        if (r < 75) return lo;
        if (r < 90) return hi - 1;
        return hi;
    endfunction

    function automatic t_item random_item(input t_action act);
        t_item it;
        int    k;
        it.act = act;
        it.sig = SIGIN_W'($urandom_range(0, 7));
        it.box = BOXIN_W'($urandom_range(0, 63));
        for (k = 0; k < NUM_COORDS; k++) it.coord[k] = pick_coord();
        return it;
    endfunction

    // classify aimed at one of the boxes in use
    function automatic t_item aimed_point();
        t_item it;
        int    n;
        int    row;
        int    k;
        it     = random_item(ACT_CLASSIFY);
        it.sig = SIGIN_W'($urandom_range(0, SIGNAL_TYPES - 1));
        n      = boxes_in_use(int'(it.sig));
        if (n > 0) begin
            row = int'(it.sig) * BOXES_PER_SIGNAL + $urandom_range(0, n - 1);
            for (k = 0; k < NUM_COORDS; k++)
                it.coord[k] = pick_near(lower_tab[row][k], upper_tab[row][k]);
            if ($urandom_range(0, 9) == 0) it.coord[$urandom_range(0, NUM_COORDS - 1)] = pick_coord();
        end
        return it;
    endfunction

    function automatic t_row item_row(input t_action act, input int sig, input int box,
                                      input logic [COORD_WIDTH-1:0] a, input logic [COORD_WIDTH-1:0] b,
                                      input logic [COORD_WIDTH-1:0] c, input logic [COORD_WIDTH-1:0] d);
        t_row r;
        r            = '0;
        r.item.act   = act;
        r.item.sig   = SIGIN_W'(sig);
        r.item.box   = BOXIN_W'(box);
        r.item.coord = {d, c, b, a};
        return r;
    endfunction

    function automatic t_row with_answer(input t_row r, input int mb, input bit f, input bit bad);
        t_row o;
        o                   = r;
        o.is_typed          = 1'b1;
        o.typed.matched_box = MATCH_W'(mb);
        o.typed.found       = f;
        o.typed.bad_signal  = bad;
        return o;
    endfunction

    function automatic t_row cfg_row(input t_count_reg idx, input int val);
        t_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = COUNT_W'(val);
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input t_row r);
        directed_rows = {directed_rows, r};
    endfunction

    // directed table: unknown signals, unused action, extreme bounds,
    // saturated counts, inclusive lower and exclusive upper edges, inverted box
    function automatic void build_directed();
        logic [COORD_WIDTH-1:0] ten;
        logic [COORD_WIDTH-1:0] five;
        logic [COORD_WIDTH-1:0] seven;
        ten   = COORD_WIDTH'(10 * ONE_Q);
        five  = COORD_WIDTH'(5 * ONE_Q);
        seven = COORD_WIDTH'(7 * ONE_Q);
        // counts still zero after reset
        add_row(with_answer(item_row(ACT_CLASSIFY, 0, 0, '0, '0, '0, '0),
                            0, 1'b0, 1'b0));
        add_row(with_answer(item_row(ACT_CLASSIFY, 4, 63,
                            C_MAX, C_MAX, C_MAX, C_MAX), 0, 1'b0, 1'b1));
        add_row(with_answer(item_row(ACT_CLASSIFY, 7, 0,
                            C_MIN, C_MIN, C_MIN, C_MIN), 0, 1'b0, 1'b1));
        add_row(item_row(ACT_NONE, 0, 0, C_ONE, C_ONE, C_ONE, C_ONE));
        add_row(item_row(ACT_WRITE_LOWER, 5, 0, '0, '0, '0, '0));
        add_row(item_row(ACT_WRITE_UPPER, 7, 63, '1, '1, '1, '1));
        // unit box at the origin, count beyond the table
        add_row(item_row(ACT_WRITE_LOWER, 0, 0, '0, '0, '0, '0));
        add_row(item_row(ACT_WRITE_UPPER, 0, 0, C_ONE, C_ONE, C_ONE, C_ONE));
        add_row(cfg_row(REG_BINS_SIG0, 127));
        add_row(with_answer(item_row(ACT_CLASSIFY, 0, 17, '0, '0, '0, '0),
                            0, 1'b1, 1'b0));
        add_row(with_answer(item_row(ACT_CLASSIFY, 0, 0, C_ONE - 1, C_ONE - 1,
                            C_ONE - 1, C_ONE - 1), 0, 1'b1, 1'b0));
        add_row(item_row(ACT_CLASSIFY, 0, 0, C_ONE, '0, '0, '0));
        // inverted box alone in its table
        add_row(item_row(ACT_WRITE_LOWER, 1, 0, ten, ten, ten, ten));
        add_row(item_row(ACT_WRITE_UPPER, 1, 0, five, five, five, five));
        add_row(cfg_row(REG_BINS_SIG1, 1));
        add_row(with_answer(item_row(ACT_CLASSIFY, 1, 0, seven, seven, seven,
                            seven), 0, 1'b0, 1'b0));
        add_row(with_answer(item_row(ACT_CLASSIFY, 1, 0, ten, ten, ten, ten),
                            0, 1'b0, 1'b0));
        // full-range box in the last slot
        add_row(item_row(ACT_WRITE_LOWER, 3, 63, C_MIN, C_MIN, C_MIN, C_MIN));
        add_row(item_row(ACT_WRITE_UPPER, 3, 63, C_MAX, C_MAX, C_MAX, C_MAX));
        add_row(cfg_row(REG_BINS_SIG3, 64));
        add_row(item_row(ACT_CLASSIFY, 3, 0, C_MIN, C_MIN, C_MIN, C_MIN));
        add_row(item_row(ACT_CLASSIFY, 3, 0, C_MAX, C_MAX, C_MAX, C_MAX));
        add_row(item_row(ACT_CLASSIFY, 3, 0, C_MAX - 1, C_MIN, '0, '1));
        add_row(cfg_row(REG_BINS_SIG2, 65));
        add_row(item_row(ACT_CLASSIFY, 2, 0, '0, '0, '0, '0));
        add_row(item_row(ACT_CLASSIFY, 2, 63, '1, '1, '1, '1));
        add_row(item_row(ACT_NONE, 7, 63, '1, '1, '1, '1));
    endfunction

    // result sink: always ready, coin-flip, or stall runs
    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(20, 200);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: sink_ready <= 1'b1;
            1: sink_ready <= ($urandom_range(0, 1) == 1);
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    sink_ready <= 1'b0;
                end else begin
                    sink_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 20);
                end
            end
        endcase
    end

    // compare each result transaction with the oldest pending verdict
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && res_if.valid === 1'b1 && sink_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("result with no classify transaction outstanding");
            end else begin
                want = pending_verdicts.pop_front();
                if (res_if.matched_box !== want.matched_box)
                    flag_mismatch($sformatf("matched_box %0d, wanted %0d",
                                            res_if.matched_box, want.matched_box));
                if (res_if.found !== want.found)
                    flag_mismatch($sformatf("found %b, wanted %b", res_if.found, want.found));
                if (res_if.bad_signal !== want.bad_signal)
                    flag_mismatch($sformatf("bad_signal %b, wanted %b",
                                            res_if.bad_signal, want.bad_signal));
            end
        end
    end

    // stimulus
    initial begin
        t_item  it;
        t_point lo;
        t_point hi;
        int     s;
        int     b;
        int     ph;
        int     sent;
        int     r;
        bit     paused;
        int     vals [4];

        item_if.valid       = 1'b0;
        item_if.action      = ACT_CLASSIFY;
        item_if.signal_type = '0;
        item_if.box_number  = '0;
        item_if.coord_one   = '0;
        item_if.coord_two   = '0;
        item_if.coord_three = '0;
        item_if.coord_four  = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = REG_BINS_SIG0;
        cfg_if.data         = '0;
        for (s = 0; s < NUM_COUNT_REGS; s++) bin_count[s] = '0;
        for (s = 0; s < TABLE_DEPTH; s++) begin
            for (b = 0; b < NUM_COORDS; b++) begin
                lower_tab[s][b] = '0;
                upper_tab[s][b] = '0;
            end
        end
        paused = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // write both bounds of every box so no scan ever reads an unwritten entry
        for (s = 0; s < SIGNAL_TYPES; s++) begin
            for (b = 0; b < BOXES_PER_SIGNAL; b++) begin
                pick_box(lo, hi);
                it.sig   = SIGIN_W'(s);
                it.box   = BOXIN_W'(b);
                it.act   = ACT_WRITE_LOWER;
                it.coord = lo;
                send_item(it, 1'b0, '0);
                it.act   = ACT_WRITE_UPPER;
                it.coord = hi;
                send_item(it, 1'b0, '0);
            end
        end

        // directed table
        build_directed();
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_drained();
                write_count(directed_rows[i].reg_idx, directed_rows[i].reg_val, 1'b1);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].is_typed,
                          directed_rows[i].typed);
            end
        end

        // random phases, one count setting each
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: vals = '{64, 64, 64, 64};
                1: vals = '{0, 1, 2, 63};
                2: vals = '{127, 65, 0, 64};
                default: begin
                    for (s = 0; s < 4; s++)
                        vals[s] = ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(0, 127);
                end
            endcase
            load_counts(vals[0], vals[1], vals[2], vals[3]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // source holds off once until every answer is back
                if (ph == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
                    hold_items();
                    while (pending_verdicts.size() != 0) @(posedge i_clk);
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_item(aimed_point(), 1'b0, '0);
                    sent++;
                end else if (r < 65) begin
                    it     = random_item(ACT_CLASSIFY);
                    it.sig = SIGIN_W'($urandom_range(0, SIGNAL_TYPES - 1));
                    send_item(it, 1'b0, '0);
                    sent++;
                end else if (r < 70) begin
                    it     = random_item(ACT_CLASSIFY);
                    it.sig = SIGIN_W'($urandom_range(4, 7));
                    send_item(it, 1'b0, '0);
                    sent++;
                end else if (r < 73) begin
                    send_item(random_item(ACT_NONE), 1'b0, '0);
                    sent++;
                end else if (r < 78) begin
                    it = random_item(($urandom_range(0, 1) == 0) ? ACT_WRITE_LOWER
                                                                  : ACT_WRITE_UPPER);
                    send_item(it, 1'b0, '0);
                    sent++;
                end else begin
                    // rewrite a whole box
                    pick_box(lo, hi);
                    it.sig   = SIGIN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 7)
                                                                    : $urandom_range(0, 3));
                    it.box   = BOXIN_W'($urandom_range(0, 63));
                    it.act   = ACT_WRITE_LOWER;
                    it.coord = lo;
                    send_item(it, 1'b0, '0);
                    it.act   = ACT_WRITE_UPPER;
                    it.coord = hi;
                    send_item(it, 1'b0, '0);
                    sent += 2;
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("four_dim_box_bin_classifier_top regression: pass");
        end else begin
            $display("four_dim_box_bin_classifier_top regression: fail");
        end
        $finish;
    end

endmodule
